// File: rtl/core/rgb_curve_lut_mapper_unit_defines.svh
// Assertion macros shared by the curve mapper RTL.
// Both sample on clk and are off while arst_n is low.
`ifndef RGB_CURVE_LUT_MAPPER_UNIT_DEFINES_SVH
`define RGB_CURVE_LUT_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcl: same-cycle check failed");

// Next-cycle implication.
`define RCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcl: next-cycle check failed");

`endif

// File: rtl/core/rcl_pkg.sv
package rcl_pkg;

	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_POINT  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_PIXEL  = 2'd3;

	localparam int unsigned NUM_CH  = 3;
	localparam logic [1:0]  CH_LAST = 2'd2;
	localparam int unsigned PIX_W   = 8;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic clear;
		logic pix_go;
		logic pt_first_wr;
		logic pt_load;
		logic fin_init;
		logic fin_load;
		logic fin_next;
		logic div_start;
		logic fill_init;
		logic fill_step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pt_bad;
		logic pt_first;
		logic pt_rise;
		logic fin_act;
		logic fin_last;
		logic div_done;
		logic fill_last;
	} sts_t;

endpackage

// File: rtl/core/rcl_ram.sv
module rcl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/rcl_div.sv
// Restoring divider, one quotient bit per cycle.
module rcl_div #(
	parameter int unsigned LEVEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [LEVEL_BITS-1:0] num,
	input  logic [LEVEL_BITS-1:0] den,
	output logic [LEVEL_BITS-1:0] quo,
	output logic [LEVEL_BITS-1:0] rem,
	output logic                  done
);

	localparam int unsigned CW = $clog2(LEVEL_BITS);

	logic [LEVEL_BITS-1:0] rem_q;
	logic [LEVEL_BITS-1:0] quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [LEVEL_BITS:0]   rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q, quo_q[LEVEL_BITS-1]};
	assign fits   = rem_sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(LEVEL_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below den when den is nonzero, so it fits in LEVEL_BITS
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? LEVEL_BITS'(rem_sh - {1'b0, den}) : rem_sh[LEVEL_BITS-1:0];
			quo_q <= {quo_q[LEVEL_BITS-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// File: rtl/core/rcl_ctrl.sv
module rcl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    op,
	input  rcl_pkg::sts_t sts,
	output rcl_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PT    = 3'd1;
	localparam logic [2:0] ST_FIN   = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
	localparam logic [2:0] ST_FILL  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       fin_mode_q;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						rcl_pkg::OP_BEGIN: cmd.clear = 1'b1;
						rcl_pkg::OP_POINT: begin
							cmd.latch = 1'b1;
							state_d   = ST_PT;
						end
						rcl_pkg::OP_FINISH: begin
							cmd.fin_init = 1'b1;
							state_d      = ST_FIN;
						end
						rcl_pkg::OP_PIXEL: cmd.pix_go = 1'b1;
						default: ;
					endcase
				end
			end
			ST_PT: begin
				state_d = ST_IDLE;
				if (sts.pt_bad) begin
					// drop: no such channel
				end else if (sts.pt_first) begin
					cmd.pt_first_wr = 1'b1;
				end else if (sts.pt_rise) begin
					cmd.pt_load = 1'b1;
					state_d     = ST_DIVGO;
				end
			end
			ST_FIN: begin
				if (sts.fin_act) begin
					cmd.fin_load = 1'b1;
					state_d      = ST_DIVGO;
				end else if (sts.fin_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.fin_next = 1'b1;
				end
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done) begin
					cmd.fill_init = 1'b1;
					state_d       = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					if (fin_mode_q && !sts.fin_last) begin
						cmd.fin_next = 1'b1;
						state_d      = ST_FIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fin_mode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fin_mode_q <= op == rcl_pkg::OP_FINISH;
			end
		end
	end

endmodule

// File: rtl/core/rcl_datapath.sv
module rcl_datapath #(
	parameter int unsigned LEVEL_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rcl_pkg::cmd_t cmd,
	output rcl_pkg::sts_t sts,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic [1:0]    channel,
	input  logic [7:0]    point_x,
	input  logic [7:0]    point_y,
	input  logic [7:0]    pix_blue,
	input  logic [7:0]    pix_green,
	input  logic [7:0]    pix_red,
	output logic          out_strobe,
	output logic [7:0]    out_blue,
	output logic [7:0]    out_green,
	output logic [7:0]    out_red
);

	localparam int unsigned LB    = LEVEL_BITS;
	localparam int unsigned VW    = (LEVEL_BITS > 8) ? LEVEL_BITS : 8;
	localparam int unsigned NCH   = rcl_pkg::NUM_CH;
	localparam int unsigned PW    = rcl_pkg::PIX_W;
	localparam logic [LB-1:0] LMAX = {LB{1'b1}};

	// mask incoming levels to the table range
	logic [VW-1:0] px_w, py_w, pb_w, pg_w, pr_w;
	assign px_w = VW'(point_x);
	assign py_w = VW'(point_y);
	assign pb_w = VW'(pix_blue);
	assign pg_w = VW'(pix_green);
	assign pr_w = VW'(pix_red);

	logic          enable_q;
	logic [1:0]    ch_q;
	logic [LB-1:0] x_q, y_q;
	logic [LB-1:0] last_x_q [0:NCH-1];
	logic [LB-1:0] last_y_q [0:NCH-1];
	logic [NCH-1:0] used_q;

	logic [LB-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [LB-1:0] q_q, r_q, k_q;

	logic          ch_ok;
	logic [1:0]    ch_i;
	logic [LB-1:0] cur_x, cur_y;
	logic          neg;
	logic [LB-1:0] ady, dx;
	logic [LB-1:0] q0, r0;
	logic          div_done;
	logic [LB:0]   r_sum;
	logic          carry;
	logic [LB-1:0] interp;
	logic          fill_last;

	assign ch_ok = ch_q <= rcl_pkg::CH_LAST;
	assign ch_i  = ch_ok ? ch_q : 2'd0;
	assign cur_x = last_x_q[ch_i];
	assign cur_y = last_y_q[ch_i];

	assign neg = y2_q < y1_q;
	assign ady = neg ? (y1_q - y2_q) : (y2_q - y1_q);
	assign dx  = x2_q - x1_q;

	rcl_div #(.LEVEL_BITS(LB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (ady),
		.den    (dx),
		.quo    (q0),
		.rem    (r0),
		.done   (div_done)
	);

	assign r_sum     = {1'b0, r_q} + {1'b0, r0};
	assign carry     = r_sum >= {1'b0, dx};
	assign interp    = neg ? (y1_q - q_q) : (y1_q + q_q);
	assign fill_last = k_q == dx;

	assign sts.pt_bad    = !ch_ok;
	assign sts.pt_first  = !used_q[ch_i] && (x_q == '0);
	assign sts.pt_rise   = x_q > cur_x;
	assign sts.fin_act   = used_q[ch_i] && (cur_x != LMAX);
	assign sts.fin_last  = ch_q == rcl_pkg::CH_LAST;
	assign sts.div_done  = div_done;
	assign sts.fill_last = fill_last;

	// enable, channel pointer and per-channel control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			ch_q     <= '0;
			used_q   <= '0;
			for (int i = 0; i < NCH; i++) begin
				last_x_q[i] <= '0;
				last_y_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (cmd.latch) begin
				ch_q <= channel;
			end else if (cmd.fin_init) begin
				ch_q <= '0;
			end else if (cmd.fin_next) begin
				ch_q <= ch_q + 2'd1;
			end
			if (cmd.clear) begin
				used_q <= '0;
				for (int i = 0; i < NCH; i++) begin
					last_x_q[i] <= '0;
					last_y_q[i] <= '0;
				end
			end
			if (cmd.pt_first_wr || cmd.pt_load) begin
				used_q[ch_i]   <= 1'b1;
				last_x_q[ch_i] <= x_q;
				last_y_q[ch_i] <= y_q;
			end
			if (cmd.fin_load) begin
				last_x_q[ch_i] <= LMAX;
				last_y_q[ch_i] <= LMAX;
			end
		end
	end

	// segment and interpolation registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			x_q <= px_w[LB-1:0];
			y_q <= py_w[LB-1:0];
		end
		if (cmd.pt_load) begin
			x1_q <= cur_x;
			y1_q <= cur_y;
			x2_q <= x_q;
			y2_q <= y_q;
		end else if (cmd.fin_load) begin
			x1_q <= cur_x;
			y1_q <= cur_y;
			x2_q <= LMAX;
			y2_q <= LMAX;
		end
		if (cmd.fill_init) begin
			q_q <= '0;
			r_q <= '0;
			k_q <= '0;
		end else if (cmd.fill_step) begin
			// advance quotient and remainder of |dy|*k/dx by one step
			k_q <= k_q + 1'b1;
			if (carry) begin
				r_q <= LB'(r_sum - {1'b0, dx});
				q_q <= q_q + q0 + 1'b1;
			end else begin
				r_q <= r_sum[LB-1:0];
				q_q <= q_q + q0;
			end
		end
	end

	// table write port, shared by all channels
	logic          wr_en;
	logic [LB-1:0] wr_addr;
	logic [LB-1:0] wr_val;
	logic [VW-1:0] wr_val_w;
	logic [PW-1:0] wr_data;

	assign wr_en    = cmd.pt_first_wr || cmd.fill_step;
	assign wr_addr  = cmd.pt_first_wr ? '0 : (x1_q + k_q);
	assign wr_val   = cmd.pt_first_wr ? y_q : (fill_last ? y2_q : interp);
	assign wr_val_w = VW'(wr_val);
	assign wr_data  = wr_val_w[PW-1:0];

	logic [LB-1:0] rd_addr [0:NCH-1];
	logic [PW-1:0] rd_data [0:NCH-1];

	assign rd_addr[0] = pb_w[LB-1:0];
	assign rd_addr[1] = pg_w[LB-1:0];
	assign rd_addr[2] = pr_w[LB-1:0];

	for (genvar g = 0; g < NCH; g++) begin : g_tab
		rcl_ram #(.WIDTH(PW), .DEPTH(1 << LB)) u_ram (
			.clk   (clk),
			.we    (wr_en && (ch_i == 2'(g))),
			.waddr (wr_addr),
			.wdata (wr_data),
			.re    (cmd.pix_go),
			.raddr (rd_addr[g]),
			.rdata (rd_data[g])
		);
	end

	// pixel stage
	logic           valid_s1;
	logic [NCH-1:0] map_s1;
	logic [PW-1:0]  blue_s1, green_s1, red_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.pix_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_go) begin
			map_s1   <= enable_q ? used_q : '0;
			blue_s1  <= pix_blue;
			green_s1 <= pix_green;
			red_s1   <= pix_red;
		end
	end

	assign out_strobe = valid_s1;
	assign out_blue   = map_s1[0] ? rd_data[0] : blue_s1;
	assign out_green  = map_s1[1] ? rd_data[1] : green_s1;
	assign out_red    = map_s1[2] ? rd_data[2] : red_s1;

endmodule

// File: rtl/core/rgb_curve_lut_mapper_unit.sv
// Pixel items: result strobed in the cycle after acceptance; one pixel per cycle while not busy.
// Point item: a rising point keeps busy high while the serial divider runs and then
// one table entry is written per cycle. Finish: up to three such segments.
// Begin item: done at acceptance, no busy time. Results cannot be stalled.
// Reset clears enable, channel flags and last points; tables are undefined until written.
`include "rgb_curve_lut_mapper_unit_defines.svh"

module rgb_curve_lut_mapper_unit #(
	parameter int unsigned LEVEL_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic [1:0] op,
	input  logic [1:0] channel,
	input  logic [7:0] point_x,
	input  logic [7:0] point_y,
	input  logic [7:0] pix_blue,
	input  logic [7:0] pix_green,
	input  logic [7:0] pix_red,
	output logic       out_strobe,
	output logic [7:0] out_blue,
	output logic [7:0] out_green,
	output logic [7:0] out_red
);

	rcl_pkg::cmd_t cmd;
	rcl_pkg::sts_t sts;

	rcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rcl_datapath #(.LEVEL_BITS(LEVEL_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.channel     (channel),
		.point_x     (point_x),
		.point_y     (point_y),
		.pix_blue    (pix_blue),
		.pix_green   (pix_green),
		.pix_red     (pix_red),
		.out_strobe  (out_strobe),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red)
	);

	`RCL_ASSERT_NEXT(a_pixel_strobes, start && !busy && (op == rcl_pkg::OP_PIXEL), out_strobe)
	`RCL_ASSERT_NOW(a_strobe_from_pixel, out_strobe, $past(start && !busy && (op == rcl_pkg::OP_PIXEL)))
	`RCL_ASSERT_NEXT(a_point_goes_busy, start && !busy && (op == rcl_pkg::OP_POINT), busy)
	`RCL_ASSERT_NEXT(a_pixel_stays_free, start && !busy && (op == rcl_pkg::OP_PIXEL), !busy)

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int LEVEL_BITS = 8;
	localparam int LEVELS = 256;
	localparam int LEVEL_TOP = 255;
	localparam logic [1:0] CH_BLUE = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED = 2'd2;
	localparam logic [1:0] CH_NONE = 2'd3;
	// a finish may run three full segments through the serial divider
	localparam int SETTLE_CYCLES = 3 * (LEVEL_BITS + LEVELS + 4);
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int RANDOM_ITEMS = 700;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] channel;
		logic [7:0] level_x;
		logic [7:0] level_y;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} tone_item_t;

	localparam int ITEM_W = $bits(tone_item_t);

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic [1:0] op;
	logic [1:0] channel;
	logic [7:0] point_x;
	logic [7:0] point_y;
	logic [7:0] pix_blue;
	logic [7:0] pix_green;
	logic [7:0] pix_red;
	logic out_strobe;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;

	// tone curve state mirrored from the block
	logic [7:0] curve_lut [3][LEVELS];
	logic [7:0] prev_x [3];
	logic [7:0] prev_y [3];
	bit ch_loaded [3];
	bit map_enable;

	pixel_t expected_pixels [$];
	int mismatches;
	int items_sent;
	int burst_left;
	int idle_cycles;
	bit no_idle;

	rgb_curve_lut_mapper_unit #(
		.LEVEL_BITS(LEVEL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.op(op),
		.channel(channel),
		.point_x(point_x),
		.point_y(point_y),
		.pix_blue(pix_blue),
		.pix_green(pix_green),
		.pix_red(pix_red),
		.out_strobe(out_strobe),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic log_mismatch(input string msg);
		if (mismatches < 10)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic void fill_span(int c, int x1, int y1, int x2, int y2);
		int dx;
		int dy;
		dx = x2 - x1;
		dy = y2 - y1;
		if (dx <= 0)
			return;
		for (int x = x1; x < x2; x++)
			curve_lut[c][x & LEVEL_TOP] = 8'(y1 + dy * (x - x1) / dx);
		curve_lut[c][x2 & LEVEL_TOP] = 8'(y2);
	endfunction

	function automatic logic [7:0] map_level(int c, logic [7:0] v);
		if (map_enable && ch_loaded[c])
			return curve_lut[c][v];
		return v;
	endfunction

	// update the curve state for one accepted item, queue the mapped pixel if any
	function automatic void apply_item(tone_item_t it);
		int c;
		pixel_t px;
		case (it.op)
			rcl_pkg::OP_BEGIN: begin
				for (int k = 0; k < rcl_pkg::NUM_CH; k++) begin
					ch_loaded[k] = 1'b0;
					prev_x[k] = '0;
					prev_y[k] = '0;
				end
			end
			rcl_pkg::OP_POINT: begin
				c = int'(it.channel);
				if (it.channel > rcl_pkg::CH_LAST)
					return;
				if (!ch_loaded[c] && it.level_x == 0)
					curve_lut[c][0] = it.level_y;
				else if (it.level_x > prev_x[c])
					fill_span(c, int'(prev_x[c]), int'(prev_y[c]),
						int'(it.level_x), int'(it.level_y));
				else
					return;
				ch_loaded[c] = 1'b1;
				prev_x[c] = it.level_x;
				prev_y[c] = it.level_y;
			end
			rcl_pkg::OP_FINISH: begin
				for (int k = 0; k < rcl_pkg::NUM_CH; k++) begin
					if (ch_loaded[k] && prev_x[k] < LEVEL_TOP) begin
						fill_span(k, int'(prev_x[k]), int'(prev_y[k]), LEVEL_TOP, LEVEL_TOP);
						prev_x[k] = 8'(LEVEL_TOP);
						prev_y[k] = 8'(LEVEL_TOP);
					end
				end
			end
			default: begin
				px.blue = map_level(0, it.blue);
				px.green = map_level(1, it.green);
				px.red = map_level(2, it.red);
				expected_pixels.push_back(px);
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// keep reads of a loaded but unfinished curve at or below its last point
	function automatic logic [7:0] safe_level(int c, logic [7:0] v);
		if (map_enable && ch_loaded[c] && v > prev_x[c])
			return 8'($urandom_range(32'(prev_x[c]), 0));
		return v;
	endfunction

	function automatic tone_item_t noise_item();
		tone_item_t it;
		it = tone_item_t'(ITEM_W'({$urandom(), $urandom()}));
		return it;
	endfunction

	function automatic tone_item_t ctrl_item(logic [1:0] code);
		tone_item_t it;
		it = noise_item();
		it.op = code;
		return it;
	endfunction

	function automatic tone_item_t point_item(logic [1:0] ch, logic [7:0] x, logic [7:0] y);
		tone_item_t it;
		it = ctrl_item(rcl_pkg::OP_POINT);
		it.channel = ch;
		it.level_x = x;
		it.level_y = y;
		return it;
	endfunction

	function automatic tone_item_t pixel_item(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		tone_item_t it;
		it = ctrl_item(rcl_pkg::OP_PIXEL);
		it.blue = safe_level(0, b);
		it.green = safe_level(1, g);
		it.red = safe_level(2, r);
		return it;
	endfunction

	task automatic send_item(input tone_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left <= 0) begin
			if (no_idle || $urandom_range(0, 3) == 0)
				gap = 0;
			else if ($urandom_range(0, 15) == 0)
				gap = $urandom_range(20, 40);
			else
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		op <= it.op;
		channel <= it.channel;
		point_x <= it.level_x;
		point_y <= it.level_y;
		pix_blue <= it.blue;
		pix_green <= it.green;
		pix_red <= it.red;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_item(it);
		items_sent++;
		burst_left--;
	endtask

	// hold off until every pixel is back and the block has finished its work
	task automatic drain_block();
		@(negedge clk);
		start <= 1'b0;
		while (expected_pixels.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input bit value);
		drain_block();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		map_enable = value;
	endtask

	task automatic test_passthrough();
		write_enable(1'b0);
		send_item(pixel_item(8'd0, 8'd0, 8'd0));
		send_item(pixel_item(8'd255, 8'd255, 8'd255));
		send_item(pixel_item(8'hAA, 8'h55, 8'h0F));
	endtask

	task automatic test_curve_build();
		send_item(ctrl_item(rcl_pkg::OP_BEGIN));
		send_item(point_item(CH_NONE, 8'd40, 8'd90));
		send_item(point_item(CH_BLUE, 8'd0, 8'd255));
		send_item(point_item(CH_BLUE, 8'd128, 8'd0));
		send_item(point_item(CH_BLUE, 8'd128, 8'd7));
		send_item(point_item(CH_BLUE, 8'd60, 8'd9));
		send_item(point_item(CH_GREEN, 8'd255, 8'd0));
		send_item(point_item(CH_GREEN, 8'd255, 8'd30));
		send_item(point_item(CH_GREEN, 8'd0, 8'd3));
		// green already ends at the top level, red is unused
		send_item(ctrl_item(rcl_pkg::OP_FINISH));
		write_enable(1'b1);
		send_item(pixel_item(8'd0, 8'd0, 8'd0));
		send_item(pixel_item(8'd255, 8'd255, 8'd255));
		send_item(pixel_item(8'd128, 8'd128, 8'd128));
		send_item(pixel_item(8'd127, 8'd254, 8'd1));
		send_item(pixel_item(8'd200, 8'd1, 8'd254));
	endtask

	task automatic test_clear_curves();
		send_item(ctrl_item(rcl_pkg::OP_BEGIN));
		send_item(pixel_item(8'd17, 8'd255, 8'd0));
		send_item(point_item(CH_RED, 8'd10, 8'd200));
		send_item(pixel_item(8'd3, 8'd99, 8'd7));
		send_item(ctrl_item(rcl_pkg::OP_FINISH));
		send_item(pixel_item(8'd10, 8'd11, 8'd255));
	endtask

	task automatic load_channel(input int c);
		int n;
		int cur;
		int step;
		cur = 0;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 3) == 0)
			send_item(point_item(2'(c), 8'd0, pick_level()));
		for (int i = 0; i < n; i++) begin
			step = ($urandom_range(0, 7) == 0) ? LEVEL_TOP : $urandom_range(1, 70);
			cur = (cur + step > LEVEL_TOP) ? LEVEL_TOP : cur + step;
			send_item(point_item(2'(c), 8'(cur), pick_level()));
			if ($urandom_range(0, 7) == 0)
				send_item(point_item(2'(c), 8'($urandom_range(0, cur)), pick_level()));
			if ($urandom_range(0, 9) == 0)
				send_item(point_item(CH_NONE, pick_level(), pick_level()));
			if ($urandom_range(0, 5) == 0)
				send_item(pixel_item(pick_level(), pick_level(), pick_level()));
			if (cur == LEVEL_TOP)
				break;
		end
	endtask

	task automatic test_random_scenes(input int target);
		int kind;
		int n;
		tone_item_t it;
		while (items_sent < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0)
				write_enable($urandom_range(0, 2) != 0);
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				send_item(ctrl_item(rcl_pkg::OP_BEGIN));
				for (int c = 0; c < rcl_pkg::NUM_CH; c++)
					if ($urandom_range(0, 3) != 0)
						load_channel(c);
				if ($urandom_range(0, 6) != 0)
					send_item(ctrl_item(rcl_pkg::OP_FINISH));
				if ($urandom_range(0, 5) == 0)
					send_item(ctrl_item(rcl_pkg::OP_FINISH));
			end else if (kind <= 8) begin
				n = $urandom_range(3, 12);
				for (int i = 0; i < n; i++) begin
					it = noise_item();
					if (it.op == rcl_pkg::OP_PIXEL)
						it = pixel_item(it.blue, it.green, it.red);
					send_item(it);
				end
			end
			n = $urandom_range(5, 40);
			for (int i = 0; i < n; i++)
				send_item(pixel_item(pick_level(), pick_level(), pick_level()));
		end
	endtask

	always @(posedge clk) begin : check_results
		pixel_t want;
		if (arst_n && out_strobe) begin
			if (expected_pixels.size() == 0) begin
				log_mismatch($sformatf("result %0d/%0d/%0d with no pixel pending",
					out_blue, out_green, out_red));
			end else begin
				want = expected_pixels.pop_front();
				if (out_blue !== want.blue)
					log_mismatch($sformatf("out_blue expected %0d got %0d",
						want.blue, out_blue));
				if (out_green !== want.green)
					log_mismatch($sformatf("out_green expected %0d got %0d",
						want.green, out_green));
				if (out_red !== want.red)
					log_mismatch($sformatf("out_red expected %0d got %0d",
						want.red, out_red));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || out_strobe || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		op = rcl_pkg::OP_BEGIN;
		channel = CH_BLUE;
		point_x = '0;
		point_y = '0;
		pix_blue = '0;
		pix_green = '0;
		pix_red = '0;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		map_enable = 1'b0;
		for (int k = 0; k < rcl_pkg::NUM_CH; k++) begin
			ch_loaded[k] = 1'b0;
			prev_x[k] = '0;
			prev_y[k] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_passthrough();
		test_curve_build();
		test_clear_curves();
		test_random_scenes(items_sent + RANDOM_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
